// ----- hdl/tmps_pkg.sv -----
// ----------------------------------------------------------------------------
// tmps_pkg
// Shared widths and constants for the triangle maximum path sum unit.
// ----------------------------------------------------------------------------
package tmps_pkg;

    localparam int VALUE_W      = 7;
    localparam int SUM_W        = 11;
    localparam int ROWS_CFG_W   = 5;
    localparam int DEF_MAX_ROWS = 16;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 5'd15;
    localparam logic [SUM_W-1:0]      SUM_MAX    = 11'd2047;

    typedef logic [VALUE_W-1:0]    value_t;
    typedef logic [SUM_W-1:0]      sum_t;
    typedef logic [ROWS_CFG_W-1:0] rows_cfg_t;

endpackage

// ----- hdl/tmps_value_if.sv -----
// ----------------------------------------------------------------------------
// tmps_value_if
// Entry channel: one triangle entry per beat.
// ----------------------------------------------------------------------------
interface tmps_value_if
    import tmps_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

// ----- hdl/tmps_sum_if.sv -----
// ----------------------------------------------------------------------------
// tmps_sum_if
// Result channel: one maximum path sum per beat.
// ----------------------------------------------------------------------------
interface tmps_sum_if
    import tmps_pkg::*;
();
    logic valid;
    logic ready;
    sum_t max_sum;

    modport source (output valid, output max_sum, input ready);
    modport sink (input valid, input max_sum, output ready);
endinterface

// ----- hdl/tmps_cfg_if.sv -----
// ----------------------------------------------------------------------------
// tmps_cfg_if
// Configuration write channel: row count per beat.
// ----------------------------------------------------------------------------
interface tmps_cfg_if
    import tmps_pkg::*;
();
    logic      valid;
    logic      ready;
    rows_cfg_t row_count;

    modport source (output valid, output row_count, input ready);
    modport sink (input valid, input row_count, output ready);
endinterface

// ----- hdl/tmps_row_buf.sv -----
// ----------------------------------------------------------------------------
// tmps_row_buf
// Row buffer of best path sums: one write and one read port, read data
// registered, write-to-read forwarding on a same-cycle address match.
// ----------------------------------------------------------------------------
module tmps_row_buf
    import tmps_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int IDX_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output sum_t             rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  sum_t             wr_data
);

    sum_t mem [MAX_ROWS];
    sum_t mem_q_reg;
    sum_t fwd_data_reg;
    logic fwd_hit_reg;
    logic fwd_hit_next;

    assign fwd_hit_next = rd_en && wr_en && (rd_addr == wr_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

endmodule

// ----- hdl/triangle_max_path_sum_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_max_path_sum_unit
// Streams triangle entries row by row from the apex and returns the largest
// apex-to-base path sum after the last entry of the last row.
//
//   channel   dir   payload            beat
//   entry     in    value[6:0]         one triangle entry
//   result    out   max_sum[10:0]      one sum per triangle
//   cfg       in    row_count[4:0]     rows per triangle
//
// one entry per cycle while entry ready is high; an entry reads the row buffer
// on acceptance and writes its sum back in the following cycle. the last entry
// passes stage s1, then its sum enters the output queue and is offered.
// reset needs no buffer sweep. results wait in a two-beat output queue; entry
// ready drops only for a last entry when that queue, counting the sum in flight
// and a beat leaving this cycle, has no room. cfg is always ready.
// ----------------------------------------------------------------------------
module triangle_max_path_sum_unit
    import tmps_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic         clk,
    input  logic         rst_n,
    tmps_cfg_if.sink     cfg,
    tmps_value_if.sink   entry,
    tmps_sum_if.source   result
);

    localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W = ($clog2(MAX_ROWS + 1) > ROWS_CFG_W) ?
                           $clog2(MAX_ROWS + 1) : ROWS_CFG_W;

    rows_cfg_t        row_count_reg;
    logic [IDX_W-1:0] row_index_reg;
    logic [IDX_W-1:0] row_index_next;
    logic [IDX_W-1:0] column_index_reg;
    logic [IDX_W-1:0] column_index_next;
    sum_t             left_parent_reg;
    sum_t             last_row_max_reg;
    sum_t             last_row_max_next;

    logic             s1_valid_reg;
    logic [IDX_W-1:0] s1_col_reg;
    logic             s1_first_row_reg;
    logic             s1_row_end_reg;
    logic             s1_last_row_reg;
    logic             s1_emit_reg;
    value_t           s1_value_reg;

    logic [1:0]       out_count_reg;
    logic [1:0]       out_count_next;
    logic [1:0]       out_pending;
    logic             out_push;
    logic             out_pop;
    sum_t             max_sum_reg;
    sum_t             max_sum_spare_reg;

    logic [CNT_W-1:0] eff_rows;
    logic             last_row;
    logic             row_end;
    logic             emit_in;
    logic             accept;

    sum_t             old_sum;
    sum_t             above;
    logic [SUM_W:0]   raw_sum;
    sum_t             new_sum;

    // effective row count
    always_comb
    begin
        eff_rows = CNT_W'(row_count_reg);
        if (row_count_reg == '0)
        begin
            eff_rows = CNT_W'(1);
        end
        if (eff_rows > CNT_W'(MAX_ROWS))
        begin
            eff_rows = CNT_W'(MAX_ROWS);
        end
    end

    assign last_row = (CNT_W'(row_index_reg) + CNT_W'(1)) >= eff_rows;
    assign row_end  = (column_index_reg >= row_index_reg);
    assign emit_in  = row_end && last_row;

    assign out_push    = s1_valid_reg && s1_emit_reg;
    assign out_pop     = (out_count_reg != 2'd0) && result.ready;
    assign out_pending = out_count_reg + 2'(out_push) - 2'(out_pop);

    assign entry.ready = !(emit_in && (out_pending >= 2'd2));
    assign accept      = entry.valid && entry.ready;
    assign cfg.ready   = 1'b1;

    // position of the next entry
    always_comb
    begin
        row_index_next    = row_index_reg;
        column_index_next = column_index_reg;
        if (row_end)
        begin
            column_index_next = '0;
            if (last_row)
            begin
                row_index_next = '0;
            end
            else
            begin
                row_index_next = row_index_reg + IDX_W'(1);
            end
        end
        else
        begin
            column_index_next = column_index_reg + IDX_W'(1);
        end
    end

    tmps_row_buf #(
        .MAX_ROWS (MAX_ROWS),
        .IDX_W    (IDX_W)
    ) u_row_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (column_index_reg),
        .rd_data (old_sum),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (new_sum)
    );

    // parent selection and saturating add
    always_comb
    begin
        if (s1_first_row_reg)
        begin
            above = '0;
        end
        else if (s1_col_reg == '0)
        begin
            above = old_sum;
        end
        else if (s1_row_end_reg)
        begin
            above = left_parent_reg;
        end
        else
        begin
            above = (left_parent_reg > old_sum) ? left_parent_reg : old_sum;
        end
        raw_sum = {1'b0, above} + (SUM_W + 1)'(s1_value_reg);
        new_sum = raw_sum[SUM_W] ? SUM_MAX : raw_sum[SUM_W-1:0];
    end

    always_comb
    begin
        last_row_max_next = last_row_max_reg;
        if (s1_last_row_reg && ((s1_col_reg == '0) || (new_sum > last_row_max_reg)))
        begin
            last_row_max_next = new_sum;
        end
    end

    assign out_count_next = out_count_reg + 2'(out_push) - 2'(out_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= ROWS_RESET;
            row_index_reg    <= '0;
            column_index_reg <= '0;
            left_parent_reg  <= '0;
            last_row_max_reg <= '0;
            s1_valid_reg     <= 1'b0;
            out_count_reg    <= 2'd0;
        end
        else
        begin
            if (cfg.valid)
            begin
                row_count_reg <= cfg.row_count;
            end
            if (accept)
            begin
                row_index_reg    <= row_index_next;
                column_index_reg <= column_index_next;
            end
            s1_valid_reg  <= accept;
            out_count_reg <= out_count_next;
            if (s1_valid_reg)
            begin
                left_parent_reg <= old_sum;
                if (s1_emit_reg)
                begin
                    last_row_max_reg <= '0;
                end
                else
                begin
                    last_row_max_reg <= last_row_max_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg       <= column_index_reg;
            s1_first_row_reg <= (row_index_reg == '0);
            s1_row_end_reg   <= row_end;
            s1_last_row_reg  <= last_row;
            s1_emit_reg      <= emit_in;
            s1_value_reg     <= entry.value;
        end
        // two-beat output queue, head drives the result channel
        if (out_pop)
        begin
            if (out_count_reg == 2'd2)
            begin
                max_sum_reg <= max_sum_spare_reg;
                if (out_push)
                begin
                    max_sum_spare_reg <= last_row_max_next;
                end
            end
            else if (out_push)
            begin
                max_sum_reg <= last_row_max_next;
            end
        end
        else if (out_push)
        begin
            if (out_count_reg == 2'd0)
            begin
                max_sum_reg <= last_row_max_next;
            end
            else
            begin
                max_sum_spare_reg <= last_row_max_next;
            end
        end
    end

    assign result.valid   = (out_count_reg != 2'd0);
    assign result.max_sum = max_sum_reg;

    // output queue has room whenever a last entry completes
    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emit_reg) |-> (out_count_reg < 2'd2))
        else $error("result queue overrun");

    // a completed triangle shows up on the result channel next cycle
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emit_reg) |=> result.valid)
        else $error("result beat missing");

    // column never passes the row it belongs to
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        column_index_reg <= row_index_reg)
        else $error("column index beyond row");

endmodule

// ----- tb/tb_triangle_max_path_sum_unit.sv -----
// ----------------------------------------------------------------------------
// tb_triangle_max_path_sum_unit
// Self-checking bench for the triangle maximum path sum unit. A clocked driver
// streams triangle entries from a queue, a clocked receiver takes the sums,
// and an in-bench row-buffer predictor works out the expected sum of every
// triangle. Row counts sweep from zero through saturation, including changes
// made part way into a triangle, with random idling on both channels, one
// long receiver hold-off and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_triangle_max_path_sum_unit;
    import tmps_pkg::*;

    localparam int MAX_ROWS    = DEF_MAX_ROWS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_WAIT = 4;
    localparam int REPORT_MAX  = 10;

    logic clk;
    logic rst_n;

    tmps_cfg_if   cfg ();
    tmps_value_if entry ();
    tmps_sum_if   result ();

    triangle_max_path_sum_unit #(
        .MAX_ROWS (MAX_ROWS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .entry  (entry),
        .result (result)
    );

    value_t      pending_entries[$];
    sum_t        expected_sums[$];
    int unsigned send_odds;
    int unsigned recv_odds;
    int unsigned send_gap;
    int unsigned recv_gap;
    int unsigned hold_left;
    int unsigned hold_requests;
    int unsigned holds_done;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned entries_queued;

    // predictor state
    rows_cfg_t   rows_setting;
    sum_t        path_best [MAX_ROWS];
    int unsigned cur_row;
    int unsigned cur_col;
    sum_t        left_sum;
    sum_t        base_max;
    sum_t        folded_sum;
    sum_t        wanted_sum;

    function automatic int unsigned eff_rows(rows_cfg_t n);
        if (n == 0)
            return 1;
        if (n > MAX_ROWS)
            return MAX_ROWS;
        return n;
    endfunction

    function automatic bit fold_entry(value_t v, output sum_t total);
        int unsigned    c;
        int unsigned    r;
        bit             last_row;
        bit             done;
        sum_t           old_sum;
        sum_t           above;
        logic [SUM_W:0] wide;
        c        = (cur_col >= MAX_ROWS) ? MAX_ROWS - 1 : cur_col;
        r        = cur_row;
        last_row = (r + 1 >= eff_rows(rows_setting));
        done     = 1'b0;
        old_sum  = path_best[c];
        if (r == 0)
            above = '0;
        else if (c == 0)
            above = old_sum;
        else if (c >= r)
            above = left_sum;
        else
            above = (left_sum > old_sum) ? left_sum : old_sum;
        wide         = above + v;
        total        = (wide > SUM_MAX) ? SUM_MAX : wide[SUM_W-1:0];
        left_sum     = old_sum;
        path_best[c] = total;
        if (last_row && (c == 0 || total > base_max))
            base_max = total;
        if (c >= r)
        begin
            if (last_row)
            begin
                total    = base_max;
                done     = 1'b1;
                cur_row  = 0;
                cur_col  = 0;
                left_sum = '0;
                base_max = '0;
            end
            else
            begin
                cur_row  = r + 1;
                cur_col  = 0;
                left_sum = '0;
            end
        end
        else
        begin
            cur_col = c + 1;
        end
        return done;
    endfunction

    function automatic value_t pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return value_t'(99);
        if (roll <= 3)
            return value_t'($urandom_range(0, 127));
        return value_t'($urandom_range(0, 99));
    endfunction

    function automatic rows_cfg_t pick_rows();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return rows_cfg_t'(16);
        if (roll == 2)
            return ($urandom_range(0, 1) == 0) ? rows_cfg_t'(31)
                                               : rows_cfg_t'($urandom_range(17, 31));
        if (roll <= 5)
            return rows_cfg_t'($urandom_range(9, 15));
        if (roll <= 11)
            return rows_cfg_t'($urandom_range(5, 8));
        return rows_cfg_t'($urandom_range(1, 4));
    endfunction

    function automatic int unsigned pick_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    task automatic push_entry(value_t v);
        pending_entries.push_back(v);
        entries_queued++;
    endtask

    task automatic push_random(int unsigned count);
        repeat (count)
            push_entry(pick_value());
    endtask

    task automatic write_rows(rows_cfg_t n);
        @(posedge clk);
        cfg.valid     <= 1'b1;
        cfg.row_count <= n;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic settle();
        while (pending_entries.size() != 0 || entry.valid || expected_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // entry driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry.valid <= 1'b0;
            entry.value <= '0;
            send_gap    <= 0;
        end
        else if (!entry.valid || entry.ready)
        begin
            if (send_gap != 0)
            begin
                entry.valid <= 1'b0;
                send_gap    <= send_gap - 1;
            end
            else if (pending_entries.size() != 0 && $urandom_range(0, 99) < send_odds)
            begin
                entry.valid <= 1'b0;
                send_gap    <= $urandom_range(0, 8);
            end
            else if (pending_entries.size() != 0)
            begin
                entry.valid <= 1'b1;
                entry.value <= pending_entries.pop_front();
            end
            else
            begin
                entry.valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            recv_gap     <= 0;
            hold_left    <= 0;
            holds_done   <= 0;
        end
        else if (holds_done != hold_requests)
        begin
            result.ready <= 1'b0;
            holds_done   <= hold_requests;
            hold_left    <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            result.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (recv_gap != 0)
        begin
            result.ready <= 1'b0;
            recv_gap     <= recv_gap - 1;
        end
        else if ($urandom_range(0, 99) < recv_odds)
        begin
            result.ready <= 1'b0;
            recv_gap     <= $urandom_range(0, 8);
        end
        else
        begin
            result.ready <= 1'b1;
        end
    end

    // prediction and checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                rows_setting = cfg.row_count;
            if (entry.valid && entry.ready)
            begin
                if (fold_entry(entry.value, folded_sum))
                    expected_sums.push_back(folded_sum);
            end
            if (result.valid && result.ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result beat: max_sum %0d", result.max_sum);
                end
                else
                begin
                    wanted_sum = expected_sums.pop_front();
                    if (result.max_sum !== wanted_sum)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("max_sum mismatch: expected %0d actual %0d",
                                     wanted_sum, result.max_sum);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int unsigned rows;
        int unsigned shape_size;
        int unsigned shape_count;
        bit          hold_done;
        rst_n          = 1'b0;
        cfg.valid      = 1'b0;
        cfg.row_count  = '0;
        entry.valid    = 1'b0;
        entry.value    = '0;
        result.ready   = 1'b0;
        send_odds      = 0;
        recv_odds      = 0;
        hold_requests  = 0;
        mismatch_count = 0;
        entries_queued = 0;
        rows_setting   = ROWS_RESET;
        cur_row        = 0;
        cur_col        = 0;
        left_sum       = '0;
        base_max       = '0;
        hold_done      = 1'b0;
        foreach (path_best[i])
            path_best[i] = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // single row, entry extremes
        write_rows(rows_cfg_t'(1));
        push_entry(value_t'(0));
        push_entry(value_t'(99));
        push_entry(value_t'(127));
        settle();
        // zero row count acts as one row
        write_rows(rows_cfg_t'(0));
        push_entry(value_t'(5));
        settle();
        // edge entries with a single parent
        write_rows(rows_cfg_t'(2));
        push_entry(value_t'(127));
        push_entry(value_t'(0));
        push_entry(value_t'(127));
        settle();
        write_rows(rows_cfg_t'(3));
        repeat (6)
            push_entry(value_t'(99));
        settle();
        // shrink the row count part way into a triangle
        write_rows(rows_cfg_t'(4));
        push_entry(value_t'(10));
        push_entry(value_t'(20));
        push_entry(value_t'(30));
        settle();
        write_rows(rows_cfg_t'(2));
        push_entry(value_t'(40));
        push_entry(value_t'(50));
        push_entry(value_t'(60));
        settle();

        while (entries_queued < 880)
        begin
            if (!hold_done && entries_queued >= 400)
            begin
                // long hold-off on the result side while entries keep coming
                send_odds = 0;
                recv_odds = 0;
                write_rows(rows_cfg_t'(1));
                hold_requests <= hold_requests + 1;
                push_random(40);
                settle();
                hold_done = 1'b1;
            end
            send_odds = pick_odds();
            recv_odds = pick_odds();
            rows      = pick_rows();
            write_rows(rows_cfg_t'(rows));
            shape_size  = eff_rows(rows_cfg_t'(rows)) * (eff_rows(rows_cfg_t'(rows)) + 1) / 2;
            shape_count = (eff_rows(rows_cfg_t'(rows)) >= 12) ? 1 : $urandom_range(1, 4);
            repeat (shape_count)
                push_random(shape_size);
            // leave a partial triangle for the next row count
            if (shape_size > 1 && $urandom_range(0, 4) == 0)
                push_random($urandom_range(1, shape_size - 1));
            settle();
        end

        // full rate to the end
        send_odds = 0;
        recv_odds = 0;
        write_rows(rows_cfg_t'(5));
        push_random(150);
        settle();
        repeat (8)
            @(posedge clk);

        if (mismatch_count == 0 && expected_sums.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
